[hw/rtl/sdfm_pkg.sv]
// Package for the stack to dual FIFO mover.
// Holds the command codes and the control and status structs that the modules share.
// Depends on nothing.

package sdfm_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_ENQUEUE = 2'd2;
	localparam logic [1:0] CMD_DEQUEUE = 2'd3;

	// Requests into the stack.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctrl_t;

	// Requests into one FIFO.
	typedef struct packed {
		logic wr;
		logic rd;
	} fifo_ctrl_t;

	// Occupancy flags of the stack or of one FIFO.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[hw/rtl/sdfm_lifo.sv]
// LIFO stack with a synchronous memory and a fill count.
// A pop reads the top entry into a data register.
// Depends on sdfm_pkg.

module sdfm_lifo #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdfm_pkg::stk_ctrl_t           ctrl,
	input  logic [sdfm_pkg::DATA_W-1:0]   wdata,
	output logic [sdfm_pkg::DATA_W-1:0]   rdata,
	output sdfm_pkg::q_status_t           status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [sdfm_pkg::DATA_W-1:0] mem [DEPTH];
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               top_idx;
	logic [sdfm_pkg::DATA_W-1:0] rd_q;

	assign top_idx      = count_q - CW'(1);
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_q <= top_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[count_q[AW-1:0]] <= wdata;
		end
		if (ctrl.pop) begin
			rd_q <= mem[top_idx[AW-1:0]];
		end
	end

	// The count can never pass the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count beyond depth");

	// The top level never pushes onto a full or pops from an empty stack.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && status.full) && !(ctrl.pop && status.empty))
		else $error("stack request against its occupancy");

	// Push and pop never come in the same cycle.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && ctrl.pop))
		else $error("stack push and pop together");

endmodule

[hw/rtl/sdfm_fifo.sv]
// Circular FIFO with a synchronous memory, head and tail pointers and a fill count.
// A read places the head entry in a data register.
// Depends on sdfm_pkg.

module sdfm_fifo #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdfm_pkg::fifo_ctrl_t          ctrl,
	input  logic [sdfm_pkg::DATA_W-1:0]   wdata,
	output logic [sdfm_pkg::DATA_W-1:0]   rdata,
	output sdfm_pkg::q_status_t           status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [sdfm_pkg::DATA_W-1:0] mem [DEPTH];
	logic [AW-1:0]               head_q;
	logic [AW-1:0]               tail_q;
	logic [CW-1:0]               count_q;
	logic [sdfm_pkg::DATA_W-1:0] rd_q;
	logic [AW-1:0]               head_nxt;
	logic [AW-1:0]               tail_nxt;

	assign head_nxt     = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign tail_nxt     = (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.wr) begin
				tail_q <= tail_nxt;
			end
			if (ctrl.rd) begin
				head_q <= head_nxt;
			end
			if (ctrl.wr && !ctrl.rd) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.rd && !ctrl.wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem[tail_q] <= wdata;
		end
		if (ctrl.rd) begin
			rd_q <= mem[head_q];
		end
	end

	// The count can never pass the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("FIFO count beyond depth");

	// Writes never hit a full FIFO and reads never hit an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.wr && status.full) && !(ctrl.rd && status.empty))
		else $error("FIFO request against its occupancy");

	// The entry read next sits a count away from the tail; checked here for the empty case.
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty FIFO with split pointers");

endmodule

[hw/rtl/stack_to_dual_fifo_mover.sv]
// Top level of the stack to dual FIFO mover: command decode, result register, status.
// Instantiates sdfm_lifo once and sdfm_fifo twice; depends on sdfm_pkg.
//
//  Channel   Handshake        Ports                                   Direction
//  --------  ---------------  --------------------------------------  ---------
//  command   start && !busy   command, queue_select, push_value       in
//  result    done (strobe)    dequeued_value, queue_was_empty         out
//
// Push, pop and dequeue commands can be issued every clock while busy is low.
// An enqueue that moves an entry reads the stack memory into the stack's data
// register when it is accepted, and the FIFO memory is then written from that
// register while busy is high.
// A dequeue result appears with done in the cycle after its command is taken.
// Reset clears all counts and pointers; memory contents are left as they are.
// The result side cannot stall: done lasts exactly one cycle.

module stack_to_dual_fifo_mover #(
	parameter int unsigned STORE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic               queue_select,
	input  logic signed [31:0] push_value,
	output logic               done,
	output logic signed [31:0] dequeued_value,
	output logic               queue_was_empty
);

	logic accept;

	sdfm_pkg::stk_ctrl_t  stk_ctl;
	sdfm_pkg::fifo_ctrl_t fa_ctl;
	sdfm_pkg::fifo_ctrl_t fb_ctl;
	sdfm_pkg::q_status_t  stk_st;
	sdfm_pkg::q_status_t  fa_st;
	sdfm_pkg::q_status_t  fb_st;
	sdfm_pkg::q_status_t  sel_st;

	logic [sdfm_pkg::DATA_W-1:0] stk_rdata;
	logic [sdfm_pkg::DATA_W-1:0] fa_rdata;
	logic [sdfm_pkg::DATA_W-1:0] fb_rdata;

	logic enq_go;
	logic deq_go;

	// Enqueue in flight: the stack entry has been read, the FIFO write is due.
	logic enq_s1;
	logic enq_sel_s1;
	// Dequeue result stage.
	logic done_q;
	logic deq_sel_s1;
	logic deq_empty_s1;

	assign accept = start && !busy;
	assign busy   = enq_s1;
	assign sel_st = queue_select ? fb_st : fa_st;

	// Decisions are taken against the counts as they stand at the accepting
	// edge; refused pushes and enqueues simply issue no request.
	always_comb begin
		stk_ctl = '0;
		enq_go  = 1'b0;
		deq_go  = 1'b0;
		if (accept) begin
			unique case (command)
				sdfm_pkg::CMD_PUSH: begin
					stk_ctl.push = !stk_st.full;
				end
				sdfm_pkg::CMD_POP: begin
					stk_ctl = '0;
				end
				sdfm_pkg::CMD_ENQUEUE: begin
					enq_go      = !stk_st.empty && !sel_st.full;
					stk_ctl.pop = !stk_st.empty && !sel_st.full;
				end
				sdfm_pkg::CMD_DEQUEUE: begin
					deq_go = 1'b1;
				end
				default: begin
					stk_ctl = '0;
				end
			endcase
		end
	end

	// A FIFO read starts at the accepting edge; the write of a moved entry
	// follows from the stack's data register once enq_s1 is set.
	always_comb begin
		fa_ctl.rd = deq_go && !queue_select && !fa_st.empty;
		fb_ctl.rd = deq_go &&  queue_select && !fb_st.empty;
		fa_ctl.wr = enq_s1 && !enq_sel_s1;
		fb_ctl.wr = enq_s1 &&  enq_sel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enq_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			enq_s1 <= enq_go;
			done_q <= deq_go;
		end
	end

	always_ff @(posedge clk) begin
		if (enq_go) begin
			enq_sel_s1 <= queue_select;
		end
		if (deq_go) begin
			deq_sel_s1   <= queue_select;
			deq_empty_s1 <= sel_st.empty;
		end
	end

	sdfm_lifo #(
		.DEPTH (STORE_DEPTH)
	) u_lifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (stk_ctl),
		.wdata  ($unsigned(push_value)),
		.rdata  (stk_rdata),
		.status (stk_st)
	);

	sdfm_fifo #(
		.DEPTH (STORE_DEPTH)
	) u_fifo_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fa_ctl),
		.wdata  (stk_rdata),
		.rdata  (fa_rdata),
		.status (fa_st)
	);

	sdfm_fifo #(
		.DEPTH (STORE_DEPTH)
	) u_fifo_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fb_ctl),
		.wdata  (stk_rdata),
		.rdata  (fb_rdata),
		.status (fb_st)
	);

	// The FIFO data registers hold the dequeued entry; an empty FIFO reads as zero.
	assign done            = done_q;
	assign queue_was_empty = deq_empty_s1;
	assign dequeued_value  = deq_empty_s1 ? '0 :
		$signed(deq_sel_s1 ? fb_rdata : fa_rdata);

	// A result is only ever shown in the cycle after a dequeue was taken.
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy && (command == sdfm_pkg::CMD_DEQUEUE)))
		else $error("result without a dequeue command");

	// A dequeue command always yields a result in the following cycle.
	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == sdfm_pkg::CMD_DEQUEUE)) |=> done)
		else $error("dequeue without a result");

	// The cycle after a moving enqueue is blocked, so two moves never overlap.
	a_enq_gap: assert property (@(posedge clk) disable iff (!arst_n)
		enq_s1 |=> !enq_s1)
		else $error("back to back enqueue moves");

	// An empty result always carries a zero value.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && queue_was_empty) |-> (dequeued_value == '0))
		else $error("empty result with a nonzero value");

endmodule

[dv/sdfm_checker.sv]
// Checker for the stack to dual FIFO mover: watches the command and result channels.
// Keeps its own copy of the stack and both FIFOs and compares every dequeue result.
// Depends on sdfm_pkg.

module sdfm_checker #(
	parameter int unsigned STORE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         command,
	input  logic               queue_select,
	input  logic signed [31:0] push_value,
	input  logic               done,
	input  logic signed [31:0] dequeued_value,
	input  logic               queue_was_empty,
	output int unsigned        failures,
	output int unsigned        outstanding
);

	typedef struct {
		logic signed [31:0] value;
		logic               was_empty;
	} dequeue_result_t;

	logic [31:0]     stack_mem [STORE_DEPTH];
	int unsigned     stack_fill;
	logic [31:0]     fifo_mem [2][STORE_DEPTH];
	int unsigned     fifo_head [2];
	int unsigned     fifo_fill [2];
	dequeue_result_t expected_dequeues [$];

	// Applies one accepted transaction to the shadow state.
	task automatic apply_command(input logic [1:0] cmd, input logic qs, input logic [31:0] val);
		dequeue_result_t r;
		int unsigned     tail;
		case (cmd)
			sdfm_pkg::CMD_PUSH: begin
				if (stack_fill < STORE_DEPTH) begin
					stack_mem[stack_fill] = val;
					stack_fill++;
				end
			end
			sdfm_pkg::CMD_ENQUEUE: begin
				// Refused when the stack is empty or the target FIFO is full.
				if (stack_fill != 0 && fifo_fill[qs] < STORE_DEPTH) begin
					tail = (fifo_head[qs] + fifo_fill[qs]) % STORE_DEPTH;
					stack_fill--;
					fifo_mem[qs][tail] = stack_mem[stack_fill];
					fifo_fill[qs]++;
				end
			end
			sdfm_pkg::CMD_DEQUEUE: begin
				if (fifo_fill[qs] == 0) begin
					r.value     = '0;
					r.was_empty = 1'b1;
				end else begin
					r.value      = fifo_mem[qs][fifo_head[qs]];
					r.was_empty  = 1'b0;
					fifo_head[qs] = (fifo_head[qs] + 1) % STORE_DEPTH;
					fifo_fill[qs]--;
				end
				expected_dequeues.push_back(r);
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		dequeue_result_t want;
		if (!arst_n) begin
			stack_fill   = 0;
			fifo_head[0] = 0;
			fifo_head[1] = 0;
			fifo_fill[0] = 0;
			fifo_fill[1] = 0;
			expected_dequeues.delete();
			failures     = 0;
		end else begin
			// The result of the previous edge's transaction is checked before this
			// edge's transaction is applied.
			if (done) begin
				if (expected_dequeues.size() == 0) begin
					$error("dequeue result with nothing expected: value %0d, empty %0b",
						dequeued_value, queue_was_empty);
					failures++;
				end else begin
					want = expected_dequeues.pop_front();
					if (dequeued_value !== want.value) begin
						$error("dequeued_value: expected %0d, actual %0d",
							want.value, dequeued_value);
						failures++;
					end
					if (queue_was_empty !== want.was_empty) begin
						$error("queue_was_empty: expected %0b, actual %0b",
							want.was_empty, queue_was_empty);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				apply_command(command, queue_select, push_value);
			end
		end
		outstanding = expected_dequeues.size();
	end

endmodule

[dv/testbench.sv]
// Top of the stack to dual FIFO mover testbench: clock, reset, stimulus and verdict.
// Instantiates stack_to_dual_fifo_mover and sdfm_checker; depends on sdfm_pkg.

module testbench;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned RANDOM_TRANSACTIONS = 377;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         command = sdfm_pkg::CMD_POP;
	logic               queue_select = 1'b0;
	logic signed [31:0] push_value = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] dequeued_value;
	logic               queue_was_empty;
	int unsigned        failures;
	int unsigned        outstanding;

	// Idle pattern state: the sender either runs back to back or draws a random idle
	// gap before each transaction, drawing the mode anew every 8 to 40 transactions.
	int unsigned        burst_left = 0;
	bit                 back_to_back = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stack_to_dual_fifo_mover #(
		.STORE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.queue_select(queue_select),
		.push_value(push_value),
		.done(done),
		.dequeued_value(dequeued_value),
		.queue_was_empty(queue_was_empty)
	);

	sdfm_checker #(
		.STORE_DEPTH(DEPTH)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.queue_select(queue_select),
		.push_value(push_value),
		.done(done),
		.dequeued_value(dequeued_value),
		.queue_was_empty(queue_was_empty),
		.failures(failures),
		.outstanding(outstanding)
	);

	// Issues one transaction and returns at the rising edge that accepts it.
	// Called at a rising edge: start is lowered for the gap when there is one and
	// then driven high, or simply kept high for back-to-back issue.
	task automatic issue(input logic [1:0] cmd, input logic qs, input logic [31:0] val);
		int unsigned gap;
		bit          taken;
		if (burst_left == 0) begin
			back_to_back = ($urandom_range(0, 3) == 0);
			burst_left   = $urandom_range(8, 40);
		end
		burst_left--;
		gap = back_to_back ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		command      <= cmd;
		queue_select <= qs;
		push_value   <= val;
		// Busy is sampled in the middle of the cycle, well away from either edge.
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	// Push values lean toward the extremes now and then; otherwise fully random.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: pick_value = 32'h7FFF_FFFF;
			1: pick_value = 32'h8000_0000;
			2: pick_value = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			default: pick_value = $urandom;
		endcase
	endfunction

	// Random mix keeps the stack and both FIFOs shallow, so the empty-stack and
	// empty-FIFO cases keep coming up alongside ordinary traffic.
	function automatic logic [1:0] pick_command();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			pick_command = sdfm_pkg::CMD_PUSH;
		end else if (r < 42) begin
			pick_command = sdfm_pkg::CMD_POP;
		end else if (r < 72) begin
			pick_command = sdfm_pkg::CMD_ENQUEUE;
		end else begin
			pick_command = sdfm_pkg::CMD_DEQUEUE;
		end
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Empty FIFOs and an empty stack first, then the data
		// extremes pushed, moved into both FIFOs and read back in FIFO order.
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b1, 32'h0);
		issue(sdfm_pkg::CMD_ENQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_POP, 1'b1, 32'hFFFF_FFFF);
		issue(sdfm_pkg::CMD_PUSH, 1'b0, 32'h7FFF_FFFF);
		issue(sdfm_pkg::CMD_PUSH, 1'b1, 32'h8000_0000);
		issue(sdfm_pkg::CMD_PUSH, 1'b0, 32'h0000_0000);
		issue(sdfm_pkg::CMD_PUSH, 1'b1, 32'hFFFF_FFFF);
		issue(sdfm_pkg::CMD_PUSH, 1'b0, 32'h0000_0001);
		issue(sdfm_pkg::CMD_ENQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_ENQUEUE, 1'b1, 32'h0);
		issue(sdfm_pkg::CMD_ENQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_POP, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b1, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b1, 32'h0);
		issue(sdfm_pkg::CMD_ENQUEUE, 1'b1, 32'h0);
		issue(sdfm_pkg::CMD_ENQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_ENQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b1, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b0, 32'h0);
		issue(sdfm_pkg::CMD_DEQUEUE, 1'b0, 32'h0);

		// Random part.
		for (int i = 0; i < RANDOM_TRANSACTIONS; i++) begin
			issue(pick_command(), 1'($urandom_range(0, 1)), pick_value());
		end

		start <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
		// A dequeue result comes from registers; the extra wait leaves room
		// for any stray strobe to show up.
		repeat (4) @(posedge clk);
		if (failures == 0) begin
			$display("stack_to_dual_fifo_mover verification clean");
		end else begin
			$display("stack_to_dual_fifo_mover verification failed");
		end
		$finish;
	end

	// The slowest correct run, about 400 transactions, takes well under 40000 time
	// units; this allows about ten times that.
	initial begin
		#400_000;
		$display("stack_to_dual_fifo_mover verification failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/sdfm_pkg.sv
hw/rtl/sdfm_lifo.sv
hw/rtl/sdfm_fifo.sv
hw/rtl/stack_to_dual_fifo_mover.sv
dv/sdfm_checker.sv
dv/testbench.sv
